@@ design/iso_datetime_to_utc_assert.svh @@
// Assertion macros for the ISO datetime to UTC converter.
`ifndef ISO_DATETIME_TO_UTC_ASSERT_SVH
`define ISO_DATETIME_TO_UTC_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define DTU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtu: same-cycle implication failed");
// next-cycle implication
`define DTU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtu: next-cycle implication failed");
`else
`define DTU_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/dtu_pkg.sv @@
// Types, constants and calendar helpers shared by the datetime to UTC converter.
package dtu_pkg;

   typedef enum logic [1:0] {
      KIND_INVALID  = 2'd0,
      KIND_DATE     = 2'd1,
      KIND_DATETIME = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SHIFT_NONE = 2'd0,
      SHIFT_BACK = 2'd1,
      SHIFT_FWD  = 2'd2
   } shift_type;

   localparam int unsigned IN_DATA_W  = 80;
   localparam int unsigned OUT_DATA_W = 56;

   localparam logic [13:0] YEAR_MAX   = 14'd9999;
   localparam logic [6:0]  MONTH_MAX  = 7'd12;
   localparam logic [6:0]  HOUR_MAX   = 7'd23;
   localparam logic [6:0]  MINUTE_MAX = 7'd59;
   localparam logic [9:0]  MILLIS_MAX = 10'd999;
   localparam logic [3:0]  MONTH_JAN  = 4'd1;
   localparam logic [3:0]  MONTH_FEB  = 4'd2;
   localparam logic [3:0]  MONTH_DEC  = 4'd12;
   localparam logic [4:0]  DEC_LEN    = 5'd31;

   localparam logic signed [12:0] DAY_MINUTES = 13'sd1440;

   // floor(x/25) = (x*RECIP25) >> 19 for x < 43690
   localparam logic [14:0] RECIP25       = 15'd20972;
   localparam int unsigned RECIP25_SHIFT = 19;
   // floor(x/60) = (x*RECIP60) >> 16 for x < 1489
   localparam logic [10:0] RECIP60       = 11'd1093;
   localparam int unsigned RECIP60_SHIFT = 16;

   // req_tdata layout, lowest field last
   typedef struct packed {
      logic [5:0]  pad;
      logic [6:0]  zone_minutes;
      logic [6:0]  zone_hours;
      logic        zone_negative;
      logic [9:0]  millis;
      logic [6:0]  second;
      logic [6:0]  minute;
      logic [6:0]  hour;
      logic [6:0]  day;
      logic [6:0]  month;
      logic [13:0] year;
   } in_type;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [4:0]         pad;
      logic [9:0]         millis;
      logic [5:0]         second;
      logic [5:0]         minute;
      logic [4:0]         hour;
      logic [4:0]         day;
      logic [3:0]         month;
      logic signed [14:0] year;
   } out_type;

   // classified item handed from front to back
   typedef struct packed {
      kind_type          kind;
      logic [13:0]       year;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [4:0]        cur_len;
      logic [4:0]        prev_len;
      logic signed [12:0] minutes;
      shift_type         shift;
      logic [5:0]        second;
      logic [9:0]        millis;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      unique case (m) inside
         4'd2:                   len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

@@ design/dtu_front.sv @@
// Front end: validates the split datetime and computes the shifted minute of day.
module dtu_front
   import dtu_pkg::*;
(
   input  in_type   item,
   input  logic     has_time,
   output work_type entry
);

   logic [28:0]        prod25;
   logic [9:0]         q25;
   logic [13:0]        q25_x25;
   logic               div4;
   logic               div16;
   logic               div25;
   logic               leap;
   logic [3:0]         mon;
   logic [4:0]         cur_len;
   logic [4:0]         prev_len;
   logic               date_ok;
   logic               time_ok;
   logic [4:0]         hr;
   logic [4:0]         zhr;
   logic [5:0]         mn;
   logic [5:0]         zmn;
   logic [10:0]        local_min;
   logic [10:0]        zone_min;
   logic signed [12:0] t;

   always_comb begin
      // year % 25 by reciprocal multiply and back-multiply check
      prod25  = 29'(item.year) * 29'(RECIP25);
      q25     = prod25[RECIP25_SHIFT +: 10];
      q25_x25 = (14'(q25) << 4) + (14'(q25) << 3) + 14'(q25);
      div25   = (q25_x25 == item.year);
      div4    = (item.year[1:0] == 2'b00);
      div16   = (item.year[3:0] == 4'b0000);
      // div4 && !div100 || div400
      leap    = div4 && (!div25 || div16);

      mon      = item.month[3:0];
      cur_len  = month_len(mon, leap);
      prev_len = (mon == MONTH_JAN) ? DEC_LEN : month_len(mon - 4'd1, leap);

      date_ok = (item.year <= YEAR_MAX) && (item.month != 7'd0) &&
                (item.month <= MONTH_MAX) && (item.day != 7'd0) &&
                (item.day <= 7'(cur_len));
      time_ok = (item.hour <= HOUR_MAX) && (item.minute <= MINUTE_MAX) &&
                (item.second <= MINUTE_MAX) && (item.millis <= MILLIS_MAX) &&
                (item.zone_hours <= HOUR_MAX) && (item.zone_minutes <= MINUTE_MAX);

      hr  = item.hour[4:0];
      mn  = item.minute[5:0];
      zhr = item.zone_hours[4:0];
      zmn = item.zone_minutes[5:0];
      local_min = (11'(hr) << 6) - (11'(hr) << 2) + 11'(mn);
      zone_min  = (11'(zhr) << 6) - (11'(zhr) << 2) + 11'(zmn);
      // UTC = local - signed offset
      if (item.zone_negative) begin
         t = $signed({2'b00, local_min}) + $signed({2'b00, zone_min});
      end else begin
         t = $signed({2'b00, local_min}) - $signed({2'b00, zone_min});
      end

      entry.kind     = KIND_INVALID;
      entry.year     = item.year;
      entry.month    = mon;
      entry.day      = item.day[4:0];
      entry.cur_len  = cur_len;
      entry.prev_len = prev_len;
      entry.minutes  = '0;
      entry.shift    = SHIFT_NONE;
      entry.second   = '0;
      entry.millis   = '0;

      if (date_ok && !has_time) begin
         entry.kind = KIND_DATE;
      end else if (date_ok && time_ok) begin
         entry.kind    = KIND_DATETIME;
         entry.minutes = t;
         entry.second  = item.second[5:0];
         entry.millis  = item.millis;
         if (t < 13'sd0) begin
            entry.shift = SHIFT_BACK;
         end else if (t >= DAY_MINUTES) begin
            entry.shift = SHIFT_FWD;
         end
      end
   end

endmodule

@@ design/dtu_queue.sv @@
// Small FIFO decoupling the classify front end from the rollover back end.
module dtu_queue
   import dtu_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  work_type         wr_data,
   input  logic             pop,
   output work_type         rd_data,
   output queue_status_type status
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   work_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

@@ design/dtu_back.sv @@
// Back end: day rollover, hour/minute split and the registered result stage.
module dtu_back
   import dtu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  work_type entry,
   input  logic     entry_valid,
   output logic     entry_pop,
   output logic     out_valid,
   input  logic     out_ready,
   output out_type  out_item,
   output kind_type out_kind
);

   logic signed [12:0] t_wide;
   logic [10:0]        t_day;
   logic [21:0]        prod60;
   logic [4:0]         hr;
   logic [10:0]        mn_wide;
   logic signed [14:0] ys;
   logic [3:0]         mo;
   logic [4:0]         dy;
   out_type            item_in;
   out_type            item_ff;
   kind_type           kind_ff;
   logic               valid_ff;
   logic               valid_in;

   always_comb begin
      case (entry.shift)
         SHIFT_BACK: t_wide = entry.minutes + DAY_MINUTES;
         SHIFT_FWD:  t_wide = entry.minutes - DAY_MINUTES;
         default:    t_wide = entry.minutes;
      endcase
      t_day   = t_wide[10:0];
      // minute of day / 60 by reciprocal multiply
      prod60  = 22'(t_day) * 22'(RECIP60);
      hr      = prod60[RECIP60_SHIFT +: 5];
      mn_wide = t_day - ((11'(hr) << 6) - (11'(hr) << 2));

      ys = $signed({1'b0, entry.year});
      mo = entry.month;
      dy = entry.day;
      case (entry.shift)
         SHIFT_BACK: begin
            if (entry.day == 5'd1) begin
               if (entry.month == MONTH_JAN) begin
                  mo = MONTH_DEC;
                  dy = DEC_LEN;
                  ys = ys - 15'sd1;
               end else begin
                  mo = entry.month - 4'd1;
                  dy = entry.prev_len;
               end
            end else begin
               dy = entry.day - 5'd1;
            end
         end
         SHIFT_FWD: begin
            if (entry.day == entry.cur_len) begin
               dy = 5'd1;
               if (entry.month == MONTH_DEC) begin
                  mo = MONTH_JAN;
                  ys = ys + 15'sd1;
               end else begin
                  mo = entry.month + 4'd1;
               end
            end else begin
               dy = entry.day + 5'd1;
            end
         end
         default: ;
      endcase

      item_in = '0;
      if (entry.kind != KIND_INVALID) begin
         item_in.year   = ys;
         item_in.month  = mo;
         item_in.day    = dy;
         item_in.second = entry.second;
         item_in.millis = entry.millis;
         if (entry.kind == KIND_DATETIME) begin
            item_in.hour   = hr;
            item_in.minute = mn_wide[5:0];
         end
      end
   end

   // load when the result register is free or being drained this cycle
   assign entry_pop = entry_valid && (!valid_ff || out_ready);

   always_comb begin
      valid_in = valid_ff;
      if (entry_pop) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_pop) begin
         item_ff <= item_in;
         kind_ff <= entry.kind;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_kind  = kind_ff;

endmodule

@@ design/iso_datetime_to_utc.sv @@
// Top level of the ISO-8601 datetime with zone offset to UTC converter.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+--------------------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: local datetime and offset, tuser: has_time
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: UTC fields, tuser: kind
//
//  One transfer in per cycle, one result per item. The front classifies in the accept
//  cycle and writes the queue; the back does rollover from the queue head into the
//  result register, which drives rsp_tvalid.
//  Sustained rate is one item per clock while rsp_tready stays high.
//  reset (synchronous) empties the queue and drops rsp_tvalid; no other state.
//  A stall on rsp fills the QUEUE_DEPTH-entry queue, after which req_tready drops.
`include "iso_datetime_to_utc_assert.svh"

module iso_datetime_to_utc
   import dtu_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // year[13:0] month[20:14] day[27:21] hour[34:28] minute[41:35] second[48:42]
   // millis[58:49] zone_negative[59] zone_hours[66:60] zone_minutes[73:67], zero pad
   input  logic [IN_DATA_W-1:0]  req_tdata,
   // has_time[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // utc_year[14:0] utc_month[18:15] utc_day[23:19] utc_hour[28:24]
   // utc_minute[34:29] utc_second[40:35] utc_millis[50:41], zero pad
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   // kind[1:0]: 0 invalid, 1 date only, 2 datetime
   output logic [1:0]            rsp_tuser
);

   in_type           req_item;
   work_type         front_entry;
   work_type         queue_head;
   queue_status_type q_status;
   logic             push;
   logic             pop;
   out_type          rsp_item;
   kind_type         rsp_kind;

   assign req_item   = in_type'(req_tdata);
   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   // classify: calendar, time and offset checks, signed minute of day
   dtu_front u_front (
      .item     (req_item),
      .has_time (req_tuser),
      .entry    (front_entry)
   );

   dtu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_entry),
      .pop     (pop),
      .rd_data (queue_head),
      .status  (q_status)
   );

   // execute: day/month/year rollover, hour and minute split
   dtu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry       (queue_head),
      .entry_valid (!q_status.empty),
      .entry_pop   (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_item    (rsp_item),
      .out_kind    (rsp_kind)
   );

   assign rsp_tdata = rsp_item;
   assign rsp_tuser = rsp_kind;

   // an invalid item carries an all-zero payload
   `DTU_ASSERT_IMP(a_invalid_zero, clock, reset,
      rsp_tvalid && (rsp_kind == KIND_INVALID), rsp_item == '0)
   // date-only results have no time of day
   `DTU_ASSERT_IMP(a_date_no_time, clock, reset,
      rsp_tvalid && (rsp_kind == KIND_DATE),
      (rsp_item.hour == '0) && (rsp_item.minute == '0) &&
      (rsp_item.second == '0) && (rsp_item.millis == '0))
   // valid results keep a legal month and a nonzero day after rollover
   `DTU_ASSERT_IMP(a_month_range, clock, reset,
      rsp_tvalid && (rsp_kind != KIND_INVALID),
      (rsp_item.month != '0) && (rsp_item.month <= MONTH_DEC) && (rsp_item.day != '0))
   // a transfer into an empty queue is visible to the back end next cycle
   `DTU_ASSERT_NXT(a_queue_fill, clock, reset,
      push && q_status.empty, !q_status.empty)

endmodule
